// ----- hdl/qbdp_pkg.sv -----
package qbdp_pkg;

   localparam int LANES    = 4;
   localparam int CODE_W   = 2;
   localparam int FIX_W    = 18;
   localparam int WEIGHT_W = 21;
   localparam int ACT_W    = 16;
   localparam int PROD_W   = 37;
   localparam int SUM_W    = 39;
   localparam int ACC_W    = 56;
   localparam int SCALE_W  = 32;
   localparam int OUT_W    = 48;
   localparam int SPLIT_W  = 28;
   localparam int FULL_W   = ACC_W + SCALE_W;
   localparam int SHIFT_W  = 16;

   localparam logic [7:0]         CODE_MAX    = 8'h7e;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

   typedef struct packed {
      logic valid;
      logic last;
   } beat_type;

   function automatic logic [FIX_W-1:0] e4m3_decode(input logic [7:0] b);
      logic [FIX_W-1:0] mant;
      logic [3:0]       expo;
      mant = {{(FIX_W-4){1'b0}}, 1'b1, b[2:0]};
      expo = b[6:3];
      if (b > CODE_MAX) begin
         return '0;
      end
      if (expo == 4'd0) begin
         return {{(FIX_W-3){1'b0}}, b[2:0]};
      end
      return mant << (expo - 4'd1);
   endfunction

endpackage

// ----- hdl/quantized_block_dot_product.sv -----
// Path: a row_end item's lane products, merged lane sum, accumulated row total, two-part
// scale products and saturated output row_sum are registered in turn.
// Throughput: one item per cycle; req_stall rises only when rsp_stall holds three row
// results in the scale pipe, a fourth row end waits to merge and the lanes hold an item.
// Reset: synchronous, active high; clears the row accumulator and all valids and sets
// output_scale to 1.0 (Q15.16).
module quantized_block_dot_product
   import qbdp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_code_byte,
   input  logic [7:0]                req_scale_code,
   input  logic [7:0]                req_offset_code,
   input  logic signed [ACT_W-1:0]   req_act_0,
   input  logic signed [ACT_W-1:0]   req_act_1,
   input  logic signed [ACT_W-1:0]   req_act_2,
   input  logic signed [ACT_W-1:0]   req_act_3,
   input  logic                      req_row_end,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [OUT_W-1:0]   rsp_row_sum,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic signed [SCALE_W-1:0] csr_output_scale
);

   logic signed [SCALE_W-1:0] output_scale_ff;
   logic [FIX_W-1:0]          scale_val;
   logic [FIX_W-1:0]          offset_val;
   logic signed [ACT_W-1:0]   act_vec [LANES];
   logic signed [PROD_W-1:0]  product [LANES];
   beat_type                  lane_ctl_ff;
   logic                      lane_hold;
   logic                      merge_hold;
   logic                      scale_hold;
   logic                      fin_valid;
   logic signed [ACC_W-1:0]   fin_acc;
   logic                      lane_load;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         output_scale_ff <= SCALE_RESET;
      end else if (csr_valid) begin
         output_scale_ff <= csr_output_scale;
      end
   end

   assign scale_val  = e4m3_decode(req_scale_code);
   assign offset_val = e4m3_decode(req_offset_code);
   assign act_vec[0] = req_act_0;
   assign act_vec[1] = req_act_1;
   assign act_vec[2] = req_act_2;
   assign act_vec[3] = req_act_3;

   assign lane_hold = lane_ctl_ff.valid && merge_hold;
   assign req_stall = lane_hold;
   assign lane_load = req_valid && !lane_hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ctl_ff <= '0;
      end else if (!lane_hold) begin
         lane_ctl_ff <= '{valid: req_valid, last: req_row_end};
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      qbdp_lane u_lane (
         .clock      (clock),
         .load       (lane_load),
         .code       (req_code_byte[CODE_W*i +: CODE_W]),
         .scale_val  (scale_val),
         .offset_val (offset_val),
         .act        (act_vec[i]),
         .product    (product[i])
      );
   end

   qbdp_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .lane_ctl  (lane_ctl_ff),
      .product   (product),
      .down_hold (scale_hold),
      .up_hold   (merge_hold),
      .fin_valid (fin_valid),
      .fin_acc   (fin_acc)
   );

   qbdp_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (fin_valid),
      .in_acc      (fin_acc),
      .out_scale   (output_scale_ff),
      .in_hold     (scale_hold),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_row_sum (rsp_row_sum)
   );

endmodule

// ----- hdl/qbdp_lane.sv -----
module qbdp_lane
   import qbdp_pkg::*;
(
   input  logic                     clock,
   input  logic                     load,
   input  logic [CODE_W-1:0]        code,
   input  logic [FIX_W-1:0]         scale_val,
   input  logic [FIX_W-1:0]         offset_val,
   input  logic signed [ACT_W-1:0]  act,
   output logic signed [PROD_W-1:0] product
);

   logic [FIX_W+CODE_W-1:0]   code_scale;
   logic signed [WEIGHT_W-1:0] weight;
   logic signed [PROD_W-1:0]  product_in;
   logic signed [PROD_W-1:0]  product_ff;

   always_comb begin
      code_scale = (FIX_W+CODE_W)'(code) * scale_val;
      weight     = $signed({1'b0, code_scale}) - $signed({3'b000, offset_val});
      product_in = PROD_W'(weight) * PROD_W'(act);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

// ----- hdl/qbdp_merge.sv -----
module qbdp_merge
   import qbdp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  beat_type                 lane_ctl,
   input  logic signed [PROD_W-1:0] product [LANES],
   input  logic                     down_hold,
   output logic                     up_hold,
   output logic                     fin_valid,
   output logic signed [ACC_W-1:0]  fin_acc
);

   beat_type                 sum_ctl_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_sat;
   logic signed [ACC_W:0]    acc_wide;
   logic                     consume;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < LANES; i++) begin
         sum_in = sum_in + SUM_W'(product[i]);
      end
   end

   assign up_hold = sum_ctl_ff.valid && sum_ctl_ff.last && down_hold;
   assign consume = sum_ctl_ff.valid && !up_hold;

   always_comb begin
      acc_wide = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(sum_ff);
      if (acc_wide[ACC_W] != acc_wide[ACC_W-1]) begin
         acc_sat = acc_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         acc_sat = acc_wide[ACC_W-1:0];
      end
   end

   assign fin_valid = consume && sum_ctl_ff.last;
   assign fin_acc   = acc_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ctl_ff <= '0;
      end else if (!up_hold) begin
         sum_ctl_ff <= lane_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (!up_hold && lane_ctl.valid) begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (consume) begin
         acc_ff <= sum_ctl_ff.last ? '0 : acc_sat;
      end
   end

`ifndef NO_ASSERTIONS
   a_clear_after_row: assert property (@(posedge clock) disable iff (reset)
      fin_valid |=> acc_ff == '0)
      else $error("accumulator not cleared after row end");

   a_hold_only_row_end: assert property (@(posedge clock) disable iff (reset)
      up_hold |-> (sum_ctl_ff.valid && sum_ctl_ff.last))
      else $error("merge stage held without a row end item");

   a_bubble_keeps_acc: assert property (@(posedge clock) disable iff (reset)
      !sum_ctl_ff.valid |=> $stable(acc_ff))
      else $error("accumulator changed on a bubble");
`endif

endmodule

// ----- hdl/qbdp_scale.sv -----
module qbdp_scale
   import qbdp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic signed [ACC_W-1:0]   in_acc,
   input  logic signed [SCALE_W-1:0] out_scale,
   output logic                      in_hold,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic signed [OUT_W-1:0]   rsp_row_sum
);

   logic                                 acc_valid_ff;
   logic signed [ACC_W-1:0]              acc_ff;
   logic                                 pp_valid_ff;
   logic signed [SPLIT_W+SCALE_W:0]      pp_lo_ff;
   logic signed [SPLIT_W+SCALE_W-1:0]    pp_hi_ff;
   logic signed [SPLIT_W+SCALE_W:0]      pp_lo_in;
   logic signed [SPLIT_W+SCALE_W-1:0]    pp_hi_in;
   logic signed [FULL_W-1:0]             full;
   logic signed [FULL_W-SHIFT_W-1:0]     quot;
   logic signed [OUT_W-1:0]              sat_in;
   logic                                 rsp_valid_ff;
   logic signed [OUT_W-1:0]              rsp_row_sum_ff;
   logic                                 out_hold;
   logic                                 pp_hold;

   assign out_hold = rsp_valid_ff && rsp_stall;
   assign pp_hold  = pp_valid_ff && out_hold;
   assign in_hold  = acc_valid_ff && pp_hold;

   always_comb begin
      pp_lo_in = (SPLIT_W+SCALE_W+1)'($signed({1'b0, acc_ff[SPLIT_W-1:0]}))
               * (SPLIT_W+SCALE_W+1)'(out_scale);
      pp_hi_in = (SPLIT_W+SCALE_W)'($signed(acc_ff[ACC_W-1:SPLIT_W]))
               * (SPLIT_W+SCALE_W)'(out_scale);
   end

   always_comb begin
      full = (FULL_W'(pp_hi_ff) <<< SPLIT_W) + FULL_W'(pp_lo_ff);
      quot = full[FULL_W-1:SHIFT_W];
      if (quot[FULL_W-SHIFT_W-1:OUT_W-1] == {(FULL_W-SHIFT_W-OUT_W+1){quot[FULL_W-SHIFT_W-1]}})
         begin
         sat_in = quot[OUT_W-1:0];
      end else begin
         sat_in = quot[FULL_W-SHIFT_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                         : {1'b0, {(OUT_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff <= 1'b0;
         pp_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!in_hold) begin
            acc_valid_ff <= in_valid;
         end
         if (!pp_hold) begin
            pp_valid_ff <= acc_valid_ff;
         end
         if (!out_hold) begin
            rsp_valid_ff <= pp_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!in_hold && in_valid) begin
         acc_ff <= in_acc;
      end
      if (!pp_hold && acc_valid_ff) begin
         pp_lo_ff <= pp_lo_in;
         pp_hi_ff <= pp_hi_in;
      end
      if (!out_hold && pp_valid_ff) begin
         rsp_row_sum_ff <= sat_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_row_sum = rsp_row_sum_ff;

`ifndef NO_ASSERTIONS
   a_hold_chain: assert property (@(posedge clock) disable iff (reset)
      in_hold |-> (pp_valid_ff && rsp_valid_ff))
      else $error("scale input held while downstream has room");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pp_valid_ff))
      else $error("result appeared without a product");

   a_no_offer_when_held: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> !in_hold)
      else $error("row total offered while scale input held");
`endif

endmodule

// ----- tb/sv/quantized_block_dot_product_tb.sv -----
module quantized_block_dot_product_tb
   import qbdp_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
   localparam longint ACC_LO = -ACC_HI - 1;
   localparam longint OUT_HI = (longint'(1) <<< (OUT_W - 1)) - 1;
   localparam longint OUT_LO = -OUT_HI - 1;
   localparam int     SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [7:0]                   code_byte;
      logic [7:0]                   scale_code;
      logic [7:0]                   offset_code;
      logic [LANES-1:0][ACT_W-1:0]  act;
      logic                         row_end;
   } dot_item_type;

   logic                      clock;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_code_byte    = '0;
   logic [7:0]                req_scale_code   = '0;
   logic [7:0]                req_offset_code  = '0;
   logic signed [ACT_W-1:0]   req_act_0        = '0;
   logic signed [ACT_W-1:0]   req_act_1        = '0;
   logic signed [ACT_W-1:0]   req_act_2        = '0;
   logic signed [ACT_W-1:0]   req_act_3        = '0;
   logic                      req_row_end      = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall        = 1'b0;
   logic signed [OUT_W-1:0]   rsp_row_sum;
   logic                      csr_valid        = 1'b0;
   logic                      csr_ready;
   logic signed [SCALE_W-1:0] csr_output_scale = '0;

   logic signed [OUT_W-1:0]   pending_row_sums [$];
   logic signed [OUT_W-1:0]   want_sum;
   longint                    row_acc;
   logic signed [SCALE_W-1:0] row_scale;
   int                        fail_count  = 0;
   int                        hold_cycles = 0;
   bit                        req_idle_on = 1'b1;
   bit                        rsp_idle_on = 1'b1;

   quantized_block_dot_product u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_code_byte    (req_code_byte),
      .req_scale_code   (req_scale_code),
      .req_offset_code  (req_offset_code),
      .req_act_0        (req_act_0),
      .req_act_1        (req_act_1),
      .req_act_2        (req_act_2),
      .req_act_3        (req_act_3),
      .req_row_end      (req_row_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row_sum      (rsp_row_sum),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_output_scale (csr_output_scale)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

   function automatic longint e4m3_value(input logic [7:0] b);
      logic [3:0] ex;
      ex = b[6:3];
      if (b > CODE_MAX) begin
         return 0;
      end
      if (ex == 4'd0) begin
         return longint'(b[2:0]);
      end
      return longint'({1'b1, b[2:0]}) << (ex - 4'd1);
   endfunction

   function automatic void fold_item(input dot_item_type it);
      longint                scale_fix;
      longint                offset_fix;
      longint                weight;
      longint                lane_sum;
      longint                next_acc;
      logic signed [87:0]    wide_acc;
      logic signed [87:0]    wide_scale;
      int                    j;
      scale_fix  = e4m3_value(it.scale_code);
      offset_fix = e4m3_value(it.offset_code);
      lane_sum   = 0;
      for (j = 0; j < LANES; j++) begin
         weight   = longint'(it.code_byte[2*j +: 2]) * scale_fix - offset_fix;
         lane_sum += weight * longint'($signed(it.act[j]));
      end
      next_acc = row_acc + lane_sum;
      if (next_acc > ACC_HI) begin
         next_acc = ACC_HI;
      end else if (next_acc < ACC_LO) begin
         next_acc = ACC_LO;
      end
      row_acc = next_acc;
      if (it.row_end) begin
         wide_acc   = 88'(row_acc);
         wide_scale = 88'(row_scale);
         wide_acc   = (wide_acc * wide_scale) >>> SHIFT_W;
         if (wide_acc > OUT_HI) begin
            wide_acc = OUT_HI;
         end else if (wide_acc < OUT_LO) begin
            wide_acc = OUT_LO;
         end
         pending_row_sums.push_back(wide_acc[OUT_W-1:0]);
         row_acc = 0;
      end
   endfunction

   function automatic int unsigned pause_len();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(10, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   function automatic dot_item_type make_item(input logic [7:0] code, input logic [7:0] sc,
                                              input logic [7:0] off,
                                              input logic [ACT_W-1:0] a0,
                                              input logic [ACT_W-1:0] a1,
                                              input logic [ACT_W-1:0] a2,
                                              input logic [ACT_W-1:0] a3,
                                              input logic last);
      dot_item_type it;
      it.code_byte   = code;
      it.scale_code  = sc;
      it.offset_code = off;
      it.act[0]      = a0;
      it.act[1]      = a1;
      it.act[2]      = a2;
      it.act[3]      = a3;
      it.row_end     = last;
      return it;
   endfunction

   function automatic logic [ACT_W-1:0] rand_act();
      case ($urandom_range(0, 11))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         3:       return 16'hffff;
         default: return ACT_W'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] rand_e4m3();
      if ($urandom_range(0, 3) == 0) begin
         return 8'($urandom);
      end
      return 8'($urandom_range(0, CODE_MAX));
   endfunction

   // --- receiver: random holds, plus long holds on request
   initial begin
      int unsigned n;
      forever begin
         if (hold_cycles != 0) begin
            n           = hold_cycles;
            hold_cycles = 0;
            rsp_stall  <= 1'b1;
            repeat (n) @(posedge clock);
         end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat (pause_len()) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_row_sums.size() == 0) begin
            $display("%0t: unexpected row_sum transfer, actual %0d", $time, rsp_row_sum);
            fail_count++;
         end else begin
            want_sum = pending_row_sums.pop_front();
            if (rsp_row_sum !== want_sum) begin
               $display("%0t: row_sum mismatch, expected %0d, actual %0d",
                        $time, want_sum, rsp_row_sum);
               fail_count++;
            end
         end
      end
   end

   task automatic req_pause();
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (pause_len()) @(posedge clock);
      end
   endtask

   task automatic send_item(input dot_item_type it);
      req_valid       <= 1'b1;
      req_code_byte   <= it.code_byte;
      req_scale_code  <= it.scale_code;
      req_offset_code <= it.offset_code;
      req_act_0       <= it.act[0];
      req_act_1       <= it.act[1];
      req_act_2       <= it.act[2];
      req_act_3       <= it.act[3];
      req_row_end     <= it.row_end;
      do @(posedge clock); while (req_stall);
      fold_item(it);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_row_sums.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_output_scale(input logic [SCALE_W-1:0] value);
      drain();
      csr_valid        <= 1'b1;
      csr_output_scale <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      row_scale  = value;
   endtask

   task automatic test_field_extremes();
      dot_item_type items [$];
      items.push_back(make_item(8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                1'b1));
      items.push_back(make_item(8'hff, 8'h7e, 8'h7f, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                1'b1));
      items.push_back(make_item(8'he4, 8'h08, 8'h01, 16'h8000, 16'h7fff, 16'hffff, 16'h0001,
                                1'b0));
      items.push_back(make_item(8'h1b, 8'h07, 8'h7e, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                1'b0));
      items.push_back(make_item(8'haa, 8'h80, 8'hff, 16'h7fff, 16'h8000, 16'h1234, 16'hedcb,
                                1'b0));
      items.push_back(make_item(8'h55, 8'h3f, 8'h40, 16'h00ff, 16'hff00, 16'h5555, 16'haaaa,
                                1'b1));
      items.push_back(make_item(8'he4, 8'h78, 8'h09, 16'h0100, 16'h0100, 16'h0100, 16'h0100,
                                1'b1));
      items.push_back(make_item(8'h00, 8'hff, 8'h00, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                                1'b0));
      items.push_back(make_item(8'h33, 8'h7f, 8'h7e, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                                1'b1));
      items.push_back(make_item(8'hcc, 8'h01, 8'h80, 16'h0001, 16'h0001, 16'h0001, 16'h0001,
                                1'b1));
      foreach (items[i]) begin
         req_pause();
         send_item(items[i]);
      end
   endtask

   task automatic test_output_scale();
      logic [SCALE_W-1:0] scales [$];
      scales = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
                 32'h0000_0001, 32'hfffe_0000};
      foreach (scales[i]) begin
         set_output_scale(scales[i]);
         req_pause();
         send_item(make_item(8'hff, 8'h7e, 8'h7f, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                             1'b1));
         req_pause();
         send_item(make_item(8'h00, 8'h00, 8'h7e, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                             1'b1));
         req_pause();
         send_item(make_item(8'h01, 8'h01, 8'h00, 16'h0003, 16'h0000, 16'h0000, 16'h0000,
                             1'b1));
      end
   endtask

   task automatic test_row_saturation();
      dot_item_type up_item;
      dot_item_type down_item;
      up_item   = make_item(8'hff, 8'h7e, 8'h7f, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
      down_item = make_item(8'hff, 8'h7e, 8'h7f, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
      set_output_scale(32'h7fff_ffff);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (60) send_item(up_item);
      repeat (2) send_item(down_item);
      down_item.row_end = 1'b1;
      send_item(down_item);
      down_item.row_end = 1'b0;
      repeat (60) send_item(down_item);
      up_item.row_end = 1'b1;
      send_item(up_item);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      drain();
   endtask

   task automatic test_backpressure();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      hold_cycles = 300;
      repeat (30) begin
         send_item(make_item(8'($urandom), rand_e4m3(), rand_e4m3(),
                             rand_act(), rand_act(), rand_act(), rand_act(), 1'b1));
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      drain();
   endtask

   task automatic test_random_rows();
      logic [SCALE_W-1:0] value;
      int                 count;
      int                 len;
      int                 p;
      for (p = 0; p < 5; p++) begin
         case (p)
            0:       value = SCALE_RESET;
            1:       value = $urandom;
            2:       value = $urandom_range(0, 1 << 18) - (1 << 17);
            3:       value = 32'h7fff_ffff;
            default: value = 32'h8000_0000;
         endcase
         set_output_scale(value);
         req_idle_on = (p != 2);
         rsp_idle_on = (p != 2);
         count = 0;
         while (count < 200) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
               req_pause();
               send_item(make_item(8'($urandom), rand_e4m3(), rand_e4m3(),
                                   rand_act(), rand_act(), rand_act(), rand_act(),
                                   i == len - 1));
               count++;
            end
         end
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      int k;
      row_acc   = 0;
      row_scale = SCALE_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_field_extremes();
      test_output_scale();
      test_row_saturation();
      test_backpressure();
      test_random_rows();
      req_valid <= 1'b0;
      for (k = 0; k < 20000 && pending_row_sums.size() != 0; k++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_row_sums.size() != 0) begin
         $display("%0t: %0d expected row_sum transfers never arrived",
                  $time, pending_row_sums.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
